### sv/mrf_pkg.sv
// Package: constants, types and the CRC-16/MODBUS byte update for the RTU request framer.
package mrf_pkg;

  typedef enum logic [0:0] {
    ReqReadHolding = 1'b0,
    ReqWriteSingle = 1'b1
  } req_type_e;

  localparam logic [7:0]  FcReadHolding = 8'd3;
  localparam logic [7:0]  FcWriteSingle = 8'd6;
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] CrcPoly       = 16'hA001;
  localparam logic [15:0] HoldingTop    = 16'd40000;
  localparam logic [15:0] HoldingBase   = 16'd40001;
  localparam logic [15:0] InputBase     = 16'd30001;
  localparam int unsigned FrameLen      = 8;
  localparam int unsigned CntW          = $clog2(FrameLen);

  typedef logic [7:0] frame_t [FrameLen];

  // One byte through the reflected CRC, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CrcPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

### sv/mrf_if.sv
// Interfaces: request channel and frame byte channel, valid/ready handshake.
interface mrf_req_if;
  logic        valid;
  logic        ready;
  logic [0:0]  req_type;
  logic [7:0]  slave_address;
  logic [15:0] register_number;
  logic [15:0] count_or_value;

  modport source (output valid, output req_type, output slave_address,
                  output register_number, output count_or_value, input ready);
  modport sink   (input valid, input req_type, input slave_address,
                  input register_number, input count_or_value, output ready);
endinterface

interface mrf_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [0:0] last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

### sv/modbus_rtu_request_framer.sv
// Top level: Modbus RTU request framer, three pipeline stages and a byte serializer.
//
//  channel  | dir | payload                                          | per transfer
//  req_i    | in  | req_type, slave_address, register_number, count  | one request
//  frame_o  | out | frame_byte, last_byte                            | one frame byte
//
//  A request enters in any cycle the first stage can move; its first byte appears
//  once it has passed stages 1 to 3 into the serializer, then one byte per cycle
//  while frame_o.ready is high.
//  Sustained throughput is set by the single-byte output port; frame bytes leave one at a time.
//  Up to four requests are in flight (three stages plus the serializer).
//  Reset clears the stage valid bits and the byte counter; payload is not reset.
//  A frame_o stall holds each loaded stage with no bubble ahead; nothing is dropped or repeated.
module modbus_rtu_request_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  mrf_req_if.sink     req_i,
  mrf_frame_if.source frame_o
);

  // stage 1: offset mapping, CRC over address and function code
  logic        s1_v_q;
  logic [7:0]  s1_addr_q, s1_fc_q;
  logic [15:0] s1_off_q, s1_opnd_q, s1_crc_q;
  // stage 2: CRC over offset bytes
  logic        s2_v_q;
  logic [7:0]  s2_addr_q, s2_fc_q;
  logic [15:0] s2_off_q, s2_opnd_q, s2_crc_q;
  // stage 3: CRC over operand bytes
  logic        s3_v_q;
  logic [7:0]  s3_addr_q, s3_fc_q;
  logic [15:0] s3_off_q, s3_opnd_q, s3_crc_q;
  // serializer
  logic                     ser_v_q;
  logic [mrf_pkg::CntW-1:0] cnt_q, cnt_d;
  mrf_pkg::frame_t          ser_byte_q;

  logic ser_last, ser_rdy, s3_rdy, s2_rdy, s1_rdy;
  logic [7:0]  fc_d;
  logic [15:0] off_d;

  assign ser_last = (cnt_q == mrf_pkg::CntW'(mrf_pkg::FrameLen - 1));
  assign ser_rdy  = !ser_v_q || (frame_o.ready && ser_last);
  assign s3_rdy   = !s3_v_q || ser_rdy;
  assign s2_rdy   = !s2_v_q || s3_rdy;
  assign s1_rdy   = !s1_v_q || s2_rdy;
  assign req_i.ready = s1_rdy;

  assign fc_d  = (req_i.req_type == 1'(mrf_pkg::ReqWriteSingle)) ?
                 mrf_pkg::FcWriteSingle : mrf_pkg::FcReadHolding;
  assign off_d = (req_i.register_number > mrf_pkg::HoldingTop) ?
                 req_i.register_number - mrf_pkg::HoldingBase :
                 req_i.register_number - mrf_pkg::InputBase;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      ser_v_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (s1_rdy) s1_v_q <= req_i.valid;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (s3_rdy) s3_v_q <= s2_v_q;
      if (ser_rdy) ser_v_q <= s3_v_q;
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ser_v_q && frame_o.ready) begin
      cnt_d = ser_last ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && req_i.valid) begin
      s1_addr_q <= req_i.slave_address;
      s1_fc_q   <= fc_d;
      s1_off_q  <= off_d;
      s1_opnd_q <= req_i.count_or_value;
      s1_crc_q  <= mrf_pkg::crc16_byte(mrf_pkg::crc16_byte(mrf_pkg::CrcInit,
                                                           req_i.slave_address), fc_d);
    end
    if (s2_rdy && s1_v_q) begin
      s2_addr_q <= s1_addr_q;
      s2_fc_q   <= s1_fc_q;
      s2_off_q  <= s1_off_q;
      s2_opnd_q <= s1_opnd_q;
      s2_crc_q  <= mrf_pkg::crc16_byte(mrf_pkg::crc16_byte(s1_crc_q, s1_off_q[15:8]),
                                       s1_off_q[7:0]);
    end
    if (s3_rdy && s2_v_q) begin
      s3_addr_q <= s2_addr_q;
      s3_fc_q   <= s2_fc_q;
      s3_off_q  <= s2_off_q;
      s3_opnd_q <= s2_opnd_q;
      s3_crc_q  <= mrf_pkg::crc16_byte(mrf_pkg::crc16_byte(s2_crc_q, s2_opnd_q[15:8]),
                                       s2_opnd_q[7:0]);
    end
    if (ser_rdy && s3_v_q) begin
      ser_byte_q[0] <= s3_addr_q;
      ser_byte_q[1] <= s3_fc_q;
      ser_byte_q[2] <= s3_off_q[15:8];
      ser_byte_q[3] <= s3_off_q[7:0];
      ser_byte_q[4] <= s3_opnd_q[15:8];
      ser_byte_q[5] <= s3_opnd_q[7:0];
      ser_byte_q[6] <= s3_crc_q[7:0];
      ser_byte_q[7] <= s3_crc_q[15:8];
    end
  end

  assign frame_o.valid      = ser_v_q;
  assign frame_o.frame_byte = ser_byte_q[cnt_q];
  assign frame_o.last_byte  = ser_last;

endmodule

### tb/modbus_rtu_request_framer_tb.sv
// Testbench: random and directed Modbus RTU requests, every frame byte checked against a predicted frame.
module modbus_rtu_request_framer_tb;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned RandomReqs = 420;

  typedef struct {
    mrf_pkg::req_type_e kind;
    logic [7:0]  slave_address;
    logic [15:0] register_number;
    logic [15:0] count_or_value;
    logic        drain_first;
  } request_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  mrf_req_if   req_if ();
  mrf_frame_if frame_if ();

  modbus_rtu_request_framer dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_if),
    .frame_o (frame_if)
  );

  request_t    pending_reqs [$];
  frame_beat_t predicted_bytes [$];
  request_t    cur_req;

  logic        req_active = 1'b0;
  logic        req_fired = 1'b0;
  logic        req_calm = 1'b0;
  int unsigned req_gap = 0;
  logic        drain_wait = 1'b0;
  logic        byte_fired = 1'b0;
  logic        sink_calm = 1'b0;
  int unsigned sink_wait = 0;

  int unsigned accepted_reqs = 0;
  int unsigned read_reqs = 0;
  int unsigned write_reqs = 0;
  int unsigned edge_40000 = 0;
  int unsigned wrapped_regs = 0;
  int unsigned drain_pauses = 0;
  int unsigned checked_bytes = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  always #5 clk = ~clk;

  function automatic logic [15:0] frame_crc16(input logic [7:0] msg [6]);
    logic [15:0] acc;
    acc = mrf_pkg::CrcInit;
    // reflected CRC, one message bit per step, LSB of each byte first
    for (int i = 0; i < 48; i++) begin
      acc = (acc[0] ^ msg[i / 8][i % 8]) ? ((acc >> 1) ^ mrf_pkg::CrcPoly) : (acc >> 1);
    end
    return acc;
  endfunction

  function automatic void predict_frame(input request_t r);
    logic [15:0] offset;
    logic [15:0] crc;
    logic [7:0]  msg [6];
    if (r.register_number > mrf_pkg::HoldingTop) begin
      offset = r.register_number - mrf_pkg::HoldingBase;
    end else begin
      offset = r.register_number - mrf_pkg::InputBase;
    end
    msg[0] = r.slave_address;
    msg[1] = (r.kind == mrf_pkg::ReqWriteSingle) ? mrf_pkg::FcWriteSingle :
                                                   mrf_pkg::FcReadHolding;
    msg[2] = offset[15:8];
    msg[3] = offset[7:0];
    msg[4] = r.count_or_value[15:8];
    msg[5] = r.count_or_value[7:0];
    crc = frame_crc16(msg);
    for (int k = 0; k < 6; k++) begin
      predicted_bytes.push_back('{msg[k], 1'b0});
    end
    predicted_bytes.push_back('{crc[7:0], 1'b0});
    predicted_bytes.push_back('{crc[15:8], 1'b1});
  endfunction

  task automatic queue_req(input mrf_pkg::req_type_e kind, input logic [7:0] addr,
                           input logic [15:0] reg_num, input logic [15:0] operand,
                           input logic drain);
    request_t r;
    r.kind = kind;
    r.slave_address = addr;
    r.register_number = reg_num;
    r.count_or_value = operand;
    r.drain_first = drain;
    pending_reqs.push_back(r);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (req_fired) begin
        req_fired = 1'b0;
        req_active = 1'b0;
        if (accepted_reqs % 32 == 0) req_calm = ($urandom_range(0, 3) == 0);
        req_gap = req_calm ? 0 : $urandom_range(0, 4);
      end
      if (!req_active) begin
        if (req_gap != 0) begin
          req_gap--;
        end else if (pending_reqs.size() != 0) begin
          if (pending_reqs[0].drain_first && predicted_bytes.size() != 0) begin
            // hold until every expected frame byte has come out
            if (!drain_wait) drain_pauses++;
            drain_wait = 1'b1;
          end else begin
            drain_wait = 1'b0;
            cur_req = pending_reqs.pop_front();
            req_active = 1'b1;
            req_if.req_type        <= cur_req.kind;
            req_if.slave_address   <= cur_req.slave_address;
            req_if.register_number <= cur_req.register_number;
            req_if.count_or_value  <= cur_req.count_or_value;
          end
        end
      end
      req_if.valid <= req_active;
    end
  end

  // frame byte sink
  always @(negedge clk) begin
    if (rst_n) begin
      if (byte_fired) begin
        byte_fired = 1'b0;
        if (checked_bytes % 48 == 0) sink_calm = ($urandom_range(0, 3) == 0);
        sink_wait = sink_calm ? 0 : $urandom_range(0, 4);
      end else if (sink_wait != 0) begin
        sink_wait--;
      end
      frame_if.ready <= (sink_wait == 0);
    end
  end

  // transfer monitor and checker
  always @(posedge clk) begin
    frame_beat_t want;
    logic        moved;
    if (rst_n) begin
      moved = 1'b0;
      if (req_if.valid && req_if.ready) begin
        predict_frame(cur_req);
        accepted_reqs++;
        if (cur_req.kind == mrf_pkg::ReqWriteSingle) write_reqs++;
        else read_reqs++;
        if (cur_req.register_number == mrf_pkg::HoldingTop) edge_40000++;
        if (cur_req.register_number < mrf_pkg::InputBase) wrapped_regs++;
        req_fired = 1'b1;
        moved = 1'b1;
      end
      if (frame_if.valid && frame_if.ready) begin
        moved = 1'b1;
        byte_fired = 1'b1;
        if (predicted_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected frame byte %02h last %0b", frame_if.frame_byte,
                     frame_if.last_byte);
          end
        end else begin
          want = predicted_bytes.pop_front();
          if (frame_if.frame_byte !== want.data || frame_if.last_byte !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("byte %0d: expected %02h last %0b, got %02h last %0b",
                       checked_bytes, want.data, want.last,
                       frame_if.frame_byte, frame_if.last_byte);
            end
          end
        end
        checked_bytes++;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("timeout: no transfer for %0d cycles", IdleLimit);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [15:0] reg_num;
    logic [15:0] operand;
    mrf_pkg::req_type_e kind;
    req_if.valid = 1'b0;
    req_if.req_type = mrf_pkg::ReqReadHolding;
    req_if.slave_address = '0;
    req_if.register_number = '0;
    req_if.count_or_value = '0;
    frame_if.ready = 1'b0;
    rst_n = 1'b0;

    queue_req(mrf_pkg::ReqReadHolding, 8'h00, 16'd40001, 16'h0001, 1'b0);
    queue_req(mrf_pkg::ReqWriteSingle, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
    queue_req(mrf_pkg::ReqReadHolding, 8'h01, 16'd40000, 16'h000A, 1'b0);
    queue_req(mrf_pkg::ReqWriteSingle, 8'h11, 16'd40000, 16'h1234, 1'b0);
    queue_req(mrf_pkg::ReqReadHolding, 8'h55, 16'd30001, 16'h0000, 1'b0);
    queue_req(mrf_pkg::ReqReadHolding, 8'hAA, 16'd30000, 16'hFFFF, 1'b0);
    queue_req(mrf_pkg::ReqWriteSingle, 8'h7F, 16'h0000, 16'h8000, 1'b0);
    queue_req(mrf_pkg::ReqWriteSingle, 8'h80, 16'h0001, 16'h7FFF, 1'b0);
    queue_req(mrf_pkg::ReqReadHolding, 8'h02, 16'd40002, 16'd125, 1'b0);
    queue_req(mrf_pkg::ReqReadHolding, 8'h03, 16'd39999, 16'd126, 1'b0);
    queue_req(mrf_pkg::ReqWriteSingle, 8'hFE, 16'd49999, 16'h5555, 1'b0);
    queue_req(mrf_pkg::ReqWriteSingle, 8'h0F, 16'd30002, 16'hAAAA, 1'b0);
    queue_req(mrf_pkg::ReqReadHolding, 8'hF0, 16'h8000, 16'h00FF, 1'b0);
    queue_req(mrf_pkg::ReqReadHolding, 8'h00, 16'h7FFF, 16'hFF00, 1'b0);

    for (int n = 0; n < RandomReqs; n++) begin
      kind = ($urandom_range(0, 1) == 1) ? mrf_pkg::ReqWriteSingle : mrf_pkg::ReqReadHolding;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: reg_num = 16'd40001 + 16'($urandom_range(0, 9998));
        4, 5:       reg_num = 16'd30001 + 16'($urandom_range(0, 9998));
        6:          reg_num = 16'($urandom_range(39995, 40005));
        7:          reg_num = 16'($urandom_range(29995, 30005));
        default:    reg_num = 16'($urandom);
      endcase
      if (kind == mrf_pkg::ReqReadHolding && $urandom_range(0, 2) != 0) begin
        operand = 16'($urandom_range(1, 125));
      end else begin
        operand = 16'($urandom);
      end
      queue_req(kind, 8'($urandom), reg_num, operand, (n % 100 == 0));
    end

    repeat (12) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    while (pending_reqs.size() != 0 || req_active) @(posedge clk);
    while (predicted_bytes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d requests (%0d reads, %0d writes), checked %0d frame bytes",
             accepted_reqs, read_reqs, write_reqs, checked_bytes);
    $display("Register 40000 hit %0d times, wrapped offsets %0d, drain pauses %0d",
             edge_40000, wrapped_regs, drain_pauses);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
sv/mrf_pkg.sv
sv/mrf_if.sv
sv/modbus_rtu_request_framer.sv
tb/modbus_rtu_request_framer_tb.sv
